// ----- sv/dmps_pkg.sv -----
package dmps_pkg;

  // Number of consensus pattern registers in the register map
  localparam int PatternRegs = 4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PATTERN_ZERO   = 3'd0,
    REG_PATTERN_ONE    = 3'd1,
    REG_PATTERN_TWO    = 3'd2,
    REG_PATTERN_THREE  = 3'd3,
    REG_PATTERN_COUNT  = 3'd4,
    REG_PATTERN_LENGTH = 3'd5,
    REG_REPORT_OFFSET  = 3'd6,
    REG_START_POSITION = 3'd7
  } reg_idx_t;

  // Reset values of the register file ("gc" and "gt", first base in low byte)
  localparam logic [63:0] PatternZeroRst = 64'h0000_0000_0000_6367;
  localparam logic [63:0] PatternOneRst  = 64'h0000_0000_0000_7467;
  localparam logic [2:0]  CountRst       = 3'd2;
  localparam logic [3:0]  LengthRst      = 4'd2;
  localparam logic [7:0]  OffsetRst      = 8'hFF;

  // Largest reportable position
  localparam logic [32:0] PosMax = 33'h0_FFFF_FFFF;

  // Register file as seen by the match stage
  typedef struct packed {
    logic [PatternRegs-1:0][63:0] pattern;
    logic [2:0]                   count;
    logic [3:0]                   length;
    logic signed [7:0]            offset;
    logic [30:0]                  start;
  } cfg_t;

  // Control carried with a word from the input stage to the match stage
  typedef struct packed {
    logic        valid;
    logic [3:0]  fill;
    logic [31:0] index;
  } stage_t;

endpackage

// ----- sv/dna_motif_position_scanner_core.sv -----
// A result passes the input stage register and then the output register to out_*.
// One base per cycle while the result stream does not stall; all pattern lanes
// compare the window in parallel. The input register and the output register
// decouple the two streams. A base that matches no pattern gives no output word.
// Reset (rst_n low at a clock edge) loads the register defaults, empties both
// stages and clears the base window, fill count and sequence index.
module dna_motif_position_scanner_core #(
  parameter int MAX_PATTERNS    = 4,
  parameter int MAX_PATTERN_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] base
  input  logic        in_tlast,   // end of sequence
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [32:0] site_position, [39:33] zero
  // Register write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  dmps_pkg::cfg_t   cfg_r;
  dmps_pkg::stage_t stage;
  logic [MAX_PATTERN_LEN-1:0][7:0] hist;
  logic             drain_ok;
  logic [32:0]      site_pos;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern[0] <= dmps_pkg::PatternZeroRst;
      cfg_r.pattern[1] <= dmps_pkg::PatternOneRst;
      cfg_r.pattern[2] <= '0;
      cfg_r.pattern[3] <= '0;
      cfg_r.count      <= dmps_pkg::CountRst;
      cfg_r.length     <= dmps_pkg::LengthRst;
      cfg_r.offset     <= dmps_pkg::OffsetRst;
      cfg_r.start      <= '0;
    end else if (cfg_we) begin
      unique case (dmps_pkg::reg_idx_t'(cfg_addr))
        dmps_pkg::REG_PATTERN_ZERO:   cfg_r.pattern[0] <= cfg_wdata;
        dmps_pkg::REG_PATTERN_ONE:    cfg_r.pattern[1] <= cfg_wdata;
        dmps_pkg::REG_PATTERN_TWO:    cfg_r.pattern[2] <= cfg_wdata;
        dmps_pkg::REG_PATTERN_THREE:  cfg_r.pattern[3] <= cfg_wdata;
        dmps_pkg::REG_PATTERN_COUNT:  cfg_r.count      <= cfg_wdata[2:0];
        dmps_pkg::REG_PATTERN_LENGTH: cfg_r.length     <= cfg_wdata[3:0];
        dmps_pkg::REG_REPORT_OFFSET:  cfg_r.offset     <= cfg_wdata[7:0];
        dmps_pkg::REG_START_POSITION: cfg_r.start      <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Window state and input register
  dmps_window #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_base  (in_tdata),
    .in_eos   (in_tlast),
    .drain_ok (drain_ok),
    .stage    (stage),
    .hist     (hist)
  );

  // Pattern compare, position and output register
  dmps_match #(
    .MAX_PATTERNS   (MAX_PATTERNS),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .stage    (stage),
    .hist     (hist),
    .drain_ok (drain_ok),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pos  (site_pos)
  );

  assign out_tdata = {7'd0, site_pos};

endmodule

// ----- sv/dmps_window.sv -----
module dmps_window #(
  parameter int MAX_PATTERN_LEN = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_base,
  input  logic                              in_eos,
  input  logic                              drain_ok,
  output dmps_pkg::stage_t                  stage,
  output logic [MAX_PATTERN_LEN-1:0][7:0]   hist
);

  localparam int WinDepth = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
  localparam logic [3:0] FillMax = 4'(MAX_PATTERN_LEN - 1);

  // Sequence state
  logic [WinDepth-1:0][7:0] win_r, win_nxt;
  logic [3:0]               fill_r, fill_nxt;
  logic [31:0]              index_r, index_nxt;

  // Input stage register
  logic                              valid_r, valid_nxt;
  logic [MAX_PATTERN_LEN-1:0][7:0]   hist_r, hist_nxt;
  logic [3:0]                        fill_s_r;
  logic [31:0]                       index_s_r;

  logic accept;

  assign in_ready = !valid_r || drain_ok;
  assign accept   = in_valid && in_ready;

  // Newest base first, then the held window
  always_comb begin
    hist_nxt[0] = in_base;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      hist_nxt[k] = win_r[k-1];
    end
  end

  // Window shift, fill count and index; end of sequence clears them
  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    index_nxt = index_r;
    if (in_eos) begin
      win_nxt   = '0;
      fill_nxt  = '0;
      index_nxt = '0;
    end else begin
      win_nxt[0] = in_base;
      for (int k = 1; k < WinDepth; k++) begin
        win_nxt[k] = win_r[k-1];
      end
      if (fill_r < FillMax) begin
        fill_nxt = fill_r + 4'd1;
      end
      if (index_r != 32'hFFFF_FFFF) begin
        index_nxt = index_r + 32'd1;
      end
    end
  end

  // Stage occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (drain_ok) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fill_r  <= '0;
      index_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        win_r   <= win_nxt;
        fill_r  <= fill_nxt;
        index_r <= index_nxt;
      end
    end
  end

  // Word payload, taken with the state seen before this base
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r    <= hist_nxt;
      fill_s_r  <= fill_r;
      index_s_r <= index_r;
    end
  end

  assign stage.valid = valid_r;
  assign stage.fill  = fill_s_r;
  assign stage.index = index_s_r;
  assign hist        = hist_r;

endmodule

// ----- sv/dmps_match.sv -----
module dmps_match #(
  parameter int MAX_PATTERNS    = 4,
  parameter int MAX_PATTERN_LEN = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dmps_pkg::cfg_t                    cfg,
  input  dmps_pkg::stage_t                  stage,
  input  logic [MAX_PATTERN_LEN-1:0][7:0]   hist,
  output logic                              drain_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [32:0]                       out_pos
);

  localparam int Lanes = (MAX_PATTERNS < dmps_pkg::PatternRegs) ?
                         MAX_PATTERNS : dmps_pkg::PatternRegs;

  logic [3:0]       len_eff;
  logic [2:0]       cnt_eff;
  logic [Lanes-1:0] lane_hit;
  logic             window_ok;
  logic             hit;
  logic [34:0]      pos_sum;
  logic [32:0]      pos_sat;

  logic        valid_r, valid_nxt;
  logic [32:0] pos_r;

  // Clamp length and count to what the hardware holds
  assign len_eff = (cfg.length > 4'(MAX_PATTERN_LEN)) ? 4'(MAX_PATTERN_LEN) : cfg.length;
  assign cnt_eff = (cfg.count > 3'(Lanes)) ? 3'(Lanes) : cfg.count;

  // One comparator lane per pattern; pattern byte j meets the base len-1-j back
  always_comb begin
    logic [7:0] sel;
    sel = '0;
    for (int c = 0; c < Lanes; c++) begin
      lane_hit[c] = (3'(c) < cnt_eff);
      for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
        sel = '0;
        for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
          if (4'(k + j + 1) == len_eff) begin
            sel = hist[k];
          end
        end
        if ((4'(j) < len_eff) && (cfg.pattern[c][8*j +: 8] != sel)) begin
          lane_hit[c] = 1'b0;
        end
      end
    end
  end

  // Enough bases of this sequence to fill the window
  assign window_ok = (len_eff != 4'd0) &&
                     (({1'b0, stage.fill} + 5'd1) >= {1'b0, len_eff});
  assign hit = window_ok && (|lane_hit);

  // Window start + offset + start coordinate, saturated high
  assign pos_sum = {3'b000, stage.index}
                 - {31'd0, (len_eff - 4'd1)}
                 + {{27{cfg.offset[7]}}, cfg.offset}
                 + {4'b0000, cfg.start};
  assign pos_sat = (!pos_sum[34] && (pos_sum[33:32] != 2'b00)) ?
                   dmps_pkg::PosMax : pos_sum[32:0];

  assign drain_ok = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (drain_ok) begin
      valid_nxt = stage.valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (drain_ok) begin
      pos_r <= pos_sat;
    end
  end

  assign out_valid = valid_r;
  assign out_pos   = pos_r;

endmodule

// ----- sv/dmps_checker.sv -----
module dmps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // Stalled result word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // Stalled result word keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A new result follows an accepted base through the input and output registers
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result word without an accepted base");

  // Pad bits above the position stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:33] == 7'd0))
    else $error("result pad bits set");

endmodule

bind dna_motif_position_scanner_core dmps_checker u_dmps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ----- verif/dmps_site_checker.sv -----
`timescale 1ns / 100ps

// Watches the base and site streams, predicts each site word from its own copy
// of the register file and scan window, and compares in order.
module dmps_site_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  output int unsigned mismatch_count,
  output int unsigned sites_pending
);

  localparam int MaxMotifs = 4;
  localparam int MaxLen    = 8;

  // Register copy
  logic [63:0]       consensus [dmps_pkg::PatternRegs];
  logic [2:0]        use_count;
  logic [3:0]        use_length;
  logic signed [7:0] site_offset;
  logic [30:0]       seq_start;

  // Scan state: history[0] is the newest previous base
  logic [7:0]  history [MaxLen-1];
  logic [3:0]  held;
  logic [31:0] base_pos;

  // Site positions still owed by the block, oldest first
  logic [32:0] site_q [$];

  // Scan one base, advance the window; returns 1 with the site when a motif hits
  function automatic bit scan_base(input logic [7:0] b, input logic last,
                                   output logic [32:0] site);
    int unsigned len;
    int unsigned cnt;
    logic [7:0]  win [MaxLen];
    bit          hit;
    bit          same;
    longint      pos;
    len  = (use_length > MaxLen) ? MaxLen : use_length;
    cnt  = (use_count > MaxMotifs) ? MaxMotifs : use_count;
    if (cnt > dmps_pkg::PatternRegs) cnt = dmps_pkg::PatternRegs;
    hit  = 1'b0;
    site = '0;
    if (len >= 1 && int'(held) + 1 >= len) begin
      // oldest base first, incoming base last
      for (int j = 0; j + 1 < len; j++) win[j] = history[len-2-j];
      win[len-1] = b;
      for (int c = 0; c < cnt; c++) begin
        same = 1'b1;
        for (int j = 0; j < len; j++)
          if (consensus[c][8*j +: 8] != win[j]) same = 1'b0;
        if (same) hit = 1'b1;
      end
      if (hit) begin
        pos = longint'(base_pos) - longint'(len) + 1 + longint'(site_offset)
              + longint'(seq_start);
        if (pos > longint'(dmps_pkg::PosMax)) pos = longint'(dmps_pkg::PosMax);
        site = pos[32:0];
      end
    end
    // window update
    if (last) begin
      foreach (history[j]) history[j] = '0;
      held     = '0;
      base_pos = '0;
    end else begin
      for (int j = MaxLen - 2; j > 0; j--) history[j] = history[j-1];
      history[0] = b;
      if (held < MaxLen - 1) held = held + 1'b1;
      if (base_pos != '1) base_pos = base_pos + 1;
    end
    return hit;
  endfunction

  task automatic log_mismatch(input string what, input logic [39:0] want,
                              input logic [39:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: site word mismatch (%s): expected %h got %h",
               $time, what, want, got);
  endtask

  always @(posedge clk) begin
    logic [32:0] site;
    logic [32:0] want;
    if (!rst_n) begin
      consensus[0] = dmps_pkg::PatternZeroRst;
      consensus[1] = dmps_pkg::PatternOneRst;
      consensus[2] = '0;
      consensus[3] = '0;
      use_count    = dmps_pkg::CountRst;
      use_length   = dmps_pkg::LengthRst;
      site_offset  = dmps_pkg::OffsetRst;
      seq_start    = '0;
      foreach (history[j]) history[j] = '0;
      held     = '0;
      base_pos = '0;
      site_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          dmps_pkg::REG_PATTERN_ZERO:   consensus[0] = cfg_wdata;
          dmps_pkg::REG_PATTERN_ONE:    consensus[1] = cfg_wdata;
          dmps_pkg::REG_PATTERN_TWO:    consensus[2] = cfg_wdata;
          dmps_pkg::REG_PATTERN_THREE:  consensus[3] = cfg_wdata;
          dmps_pkg::REG_PATTERN_COUNT:  use_count    = cfg_wdata[2:0];
          dmps_pkg::REG_PATTERN_LENGTH: use_length   = cfg_wdata[3:0];
          dmps_pkg::REG_REPORT_OFFSET:  site_offset  = cfg_wdata[7:0];
          dmps_pkg::REG_START_POSITION: seq_start    = cfg_wdata[30:0];
          default: ;
        endcase
      end
      // compare site word with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (site_q.size() == 0) begin
          log_mismatch("no site expected", '0, out_tdata);
        end else begin
          want = site_q.pop_front();
          if (out_tdata !== {7'b0, want})
            log_mismatch("site_position", {7'b0, want}, out_tdata);
        end
      end
      // predict from the accepted base word
      if (in_tvalid && in_tready) begin
        if (scan_base(in_tdata, in_tlast, site)) site_q.insert(site_q.size(), site);
      end
    end
    sites_pending <= site_q.size();
  end

endmodule

// ----- verif/tb_dna_motif_position_scanner_core.sv -----
`timescale 1ns / 100ps

module tb_dna_motif_position_scanner_core;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [63:0] cfg_wdata  = '0;

  int unsigned mismatch_count;
  int unsigned sites_pending;

  // Sender and receiver pacing
  int unsigned burst_left = 0;
  bit          tx_calm    = 1'b0;
  int unsigned rx_mode    = 0;
  int unsigned stall_left = 0;

  // Active motif setup, used to build matching runs
  logic [63:0] motif [dmps_pkg::PatternRegs];
  int unsigned motif_len;
  int unsigned motif_cnt;

  dna_motif_position_scanner_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  dmps_site_checker u_site_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .sites_pending  (sites_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: always ready, coin flip, or stall runs
  always @(posedge clk) begin
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
          stall_left <= $urandom_range(0, 7);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // Send one base word in bursts; ready is sampled mid-cycle
  task automatic push_base(input logic [7:0] b, input logic last);
    bit          ready;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = tx_calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do begin
      @(negedge clk);
      ready = in_tready;
      @(posedge clk);
    end while (!ready);
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      push_base(s[i], last_at_end && i == s.len() - 1);
  endtask

  // Hold off until every predicted site has come out and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sites_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input dmps_pkg::reg_idx_t idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [63:0] p0, p1, p2, p3, input logic [2:0] cnt,
                             input logic [3:0] len, input logic [7:0] off,
                             input logic [30:0] start);
    write_reg(dmps_pkg::REG_PATTERN_ZERO, p0);
    write_reg(dmps_pkg::REG_PATTERN_ONE, p1);
    write_reg(dmps_pkg::REG_PATTERN_TWO, p2);
    write_reg(dmps_pkg::REG_PATTERN_THREE, p3);
    write_reg(dmps_pkg::REG_PATTERN_COUNT, 64'(cnt));
    write_reg(dmps_pkg::REG_PATTERN_LENGTH, 64'(len));
    write_reg(dmps_pkg::REG_REPORT_OFFSET, 64'(off));
    write_reg(dmps_pkg::REG_START_POSITION, 64'(start));
    cfg_we <= 1'b0;
    motif[0]  = p0;
    motif[1]  = p1;
    motif[2]  = p2;
    motif[3]  = p3;
    motif_len = (len > 8) ? 8 : len;
    motif_cnt = (cnt > dmps_pkg::PatternRegs) ? dmps_pkg::PatternRegs : cnt;
  endtask

  function automatic logic [63:0] pack_motif(input string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [7:0] rand_letter();
    string abc;
    abc = "ACGTNacgtn";
    return abc[$urandom_range(0, 9)];
  endfunction

  // Mostly nucleotide letters, sometimes all-zero, all-one or raw bytes
  function automatic logic [63:0] rand_motif();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = {$urandom, $urandom};
      default: for (int i = 0; i < 8; i++) v[8*i +: 8] = rand_letter();
    endcase
    return v;
  endfunction

  // Random register setup with the extremes weighted in
  task automatic random_config();
    logic [2:0]  cnt;
    logic [3:0]  len;
    logic [7:0]  off;
    logic [30:0] start;
    case ($urandom_range(0, 9))
      0: len = 4'd0;
      1: len = 4'($urandom_range(9, 15));
      2: len = 4'd8;
      3: len = 4'd1;
      default: len = 4'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 7))
      0: cnt = 3'd0;
      1: cnt = 3'($urandom_range(5, 7));
      default: cnt = 3'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 5))
      0: off = 8'h80;
      1: off = 8'h7F;
      2: off = 8'h00;
      default: off = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 4))
      0: start = '0;
      1: start = '1;
      2: start = 31'($urandom_range(0, 1000));
      default: start = 31'($urandom);
    endcase
    load_config(rand_motif(), rand_motif(), rand_motif(), rand_motif(), cnt, len, off, start);
  endtask

  // Random bases: mostly whole motifs (sometimes with one base broken),
  // plus random letters and raw byte noise
  task automatic scan_random(input int unsigned n_bases);
    logic [7:0]  run_q [$];
    logic [7:0]  b;
    int unsigned pick;
    int unsigned r;
    for (int unsigned sent = 0; sent < n_bases; sent++) begin
      if (run_q.size() == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60 && motif_cnt != 0 && motif_len != 0) begin
          pick = $urandom_range(0, motif_cnt - 1);
          for (int j = 0; j < motif_len; j++)
            run_q.insert(run_q.size(), motif[pick][8*j +: 8]);
          if ($urandom_range(0, 4) == 0)
            run_q[$urandom_range(0, motif_len - 1)] = rand_letter();
        end else if (r < 85) begin
          repeat ($urandom_range(1, 6)) run_q.insert(run_q.size(), rand_letter());
        end else begin
          run_q.insert(run_q.size(), 8'($urandom_range(0, 255)));
        end
      end
      b = run_q.pop_front();
      push_base(b, $urandom_range(0, 39) == 0);
    end
  endtask

  // Stimulus
  initial begin
    int unsigned total;
    int unsigned n_bases;
    motif[0]  = dmps_pkg::PatternZeroRst;
    motif[1]  = dmps_pkg::PatternOneRst;
    motif[2]  = '0;
    motif[3]  = '0;
    motif_len = dmps_pkg::LengthRst;
    motif_cnt = dmps_pkg::CountRst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup: "gc"/"gt" hits with negative positions, case sensitivity,
    // restart after end of sequence, byte extremes
    rx_mode = 2;
    send_text("gcgtGCg", 1'b1);
    send_text("c", 1'b0);
    push_base(8'h00, 1'b0);
    push_base(8'hFF, 1'b1);
    settle();

    // oversize length and count, top offset and start
    rx_mode = 1;
    load_config(pack_motif("ACGTACGT"), '1, '0, pack_motif("TTTTTTTT"),
                3'd7, 4'd15, 8'h7F, 31'h7FFF_FFFF);
    send_text("ACGTACGTA", 1'b1);
    settle();

    // zero length: no compare even on all-zero motifs and bases
    load_config('0, '0, '0, '0, 3'd4, 4'd0, 8'h00, '0);
    push_base(8'h00, 1'b0);
    push_base(8'h00, 1'b1);
    settle();

    // zero count
    load_config(pack_motif("A"), '0, '0, '0, 3'd0, 4'd1, 8'h00, '0);
    send_text("A", 1'b1);
    settle();

    // single base, garbage in unused motif bytes, lowest offset
    load_config(64'hFFFF_FFFF_FFFF_FF41, '0, '0, '0, 3'd1, 4'd1, 8'h80, '0);
    send_text("Aa", 1'b1);
    settle();

    // random phases
    total = 24;
    while (total < 1700) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_mode = $urandom_range(0, 2);
      random_config();
      n_bases = $urandom_range(60, 150);
      scan_random(n_bases);
      total += n_bases;
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && sites_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- dna_motif_position_scanner_core.f -----
sv/dmps_pkg.sv
sv/dmps_window.sv
sv/dmps_match.sv
sv/dna_motif_position_scanner_core.sv
sv/dmps_checker.sv
verif/dmps_site_checker.sv
verif/tb_dna_motif_position_scanner_core.sv
